@@ rtl/firsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: shared package
// Field widths, register indexes and result kinds used across the block.
// ----------------------------------------------------------------------------
package firsr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int TAPS_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROUND_SH   = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_01   = 3'd1,
    REG_COEF_23   = 3'd2,
    REG_COEF_45   = 3'd3,
    REG_COEF_67   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_FILTERED = 1'b0,
    KIND_STATE    = 1'b1
  } kind_t;

endpackage
`default_nettype wire

@@ rtl/firsr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: channel interfaces
// Valid/ready channels for input samples and result words.
// ----------------------------------------------------------------------------
interface firsr_in_if;
  import firsr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink   (input valid, input sample, input end_of_block, output ready);
endinterface

interface firsr_out_if;
  import firsr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t value;
  logic    kind;
  logic    final_result;

  modport source (output valid, output value, output kind, output final_result,
                  input ready);
  modport sink   (input valid, input value, input kind, input final_result,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/firsr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: front end
// Holds the configuration and delay line, multiplies and sums each sample,
// and hands a job (filtered word plus state snapshot) to the queue.
// ----------------------------------------------------------------------------
module firsr_front #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  firsr_in_if.sink                                        in_ch,
  input  wire logic                                       cfg_we,
  input  wire logic [firsr_pkg::CFG_IDX_W-1:0]            cfg_idx,
  input  wire logic [firsr_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  output logic                                            job_valid,
  input  wire logic                                       job_ready,
  output firsr_pkg::sample_t                              job_value,
  output logic [$clog2(MAX_TAPS)-1:0]                     job_cnt,
  output logic [MAX_TAPS-2:0][firsr_pkg::SAMPLE_W-1:0]    job_state
);
  import firsr_pkg::*;

  localparam int CW     = $clog2(MAX_TAPS);
  localparam int DL     = MAX_TAPS - 1;
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'(2 ** (ROUND_SH - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_W - 1)));

  logic [TAPS_W-1:0]         tap_count_r;
  logic signed [COEF_W-1:0]  coef_r [MAX_TAPS];
  sample_t                   dl_r [DL];

  logic [TAPS_W-1:0]         taps_eff;
  logic [CW-1:0]             nstate;
  sample_t                   op [MAX_TAPS];
  logic signed [PROD_W-1:0]  prod_nxt [MAX_TAPS];
  logic [DL-1:0][SAMPLE_W-1:0] state_nxt;

  logic                      s1_v_r;
  logic signed [PROD_W-1:0]  prod_r [MAX_TAPS];
  logic [DL-1:0][SAMPLE_W-1:0] s1_state_r;
  logic [CW-1:0]             s1_cnt_r;

  logic                      s2_v_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [DL-1:0][SAMPLE_W-1:0] s2_state_r;
  logic [CW-1:0]             s2_cnt_r;
  logic signed [ACC_W-1:0]   q;

  logic in_acc, s1_ready, s2_ready, s1_move;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPS_W'(1);
    end else if (cfg_we && cfg_idx == REG_TAP_COUNT) begin
      tap_count_r <= cfg_wdata[TAPS_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_coef
    localparam logic [CFG_IDX_W-1:0] REG_IDX = CFG_IDX_W'(int'(REG_COEF_01) + k / 2);
    localparam int LSB = (k % 2) * COEF_W;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[k] <= '0;
      end else if (cfg_we && cfg_idx == REG_IDX) begin
        coef_r[k] <= cfg_wdata[LSB +: COEF_W];
      end
    end
  end

  always_comb begin
    priority if (tap_count_r == '0) begin
      taps_eff = TAPS_W'(1);
    end else if (tap_count_r > TAPS_W'(MAX_TAPS)) begin
      taps_eff = TAPS_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_r;
    end
  end
  assign nstate = CW'(taps_eff - TAPS_W'(1));

  // handshake between stages
  assign s2_ready    = !s2_v_r || job_ready;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign s1_move     = s1_v_r && s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc      = in_ch.valid && s1_ready;

  // tap operands and products; unused taps get a zero product
  always_comb begin
    op[0] = in_ch.sample;
    for (int j = 1; j < MAX_TAPS; j++) begin
      op[j] = dl_r[j-1];
    end
    for (int j = 0; j < MAX_TAPS; j++) begin
      if (TAPS_W'(j) < taps_eff) begin
        prod_nxt[j] = PROD_W'(coef_r[j]) * PROD_W'(op[j]);
      end else begin
        prod_nxt[j] = '0;
      end
    end
    for (int i = 0; i < DL; i++) begin
      state_nxt[i] = op[i];
    end
  end

  // delay line: shift on each sample, clear after the last of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        dl_r[i] <= '0;
      end
    end else if (in_acc) begin
      for (int i = 0; i < DL; i++) begin
        dl_r[i] <= in_ch.end_of_block ? sample_t'(0) : sample_t'(state_nxt[i]);
      end
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s2_ready) begin
      s1_v_r <= 1'b0;
    end
    if (in_acc) begin
      prod_r     <= prod_nxt;
      s1_state_r <= state_nxt;
      s1_cnt_r   <= in_ch.end_of_block ? nstate : '0;
    end
  end

  // stage 2: sum with rounding bias
  always_comb begin
    acc_nxt = BIAS;
    for (int j = 0; j < MAX_TAPS; j++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_move) begin
      s2_v_r <= 1'b1;
    end else if (job_ready) begin
      s2_v_r <= 1'b0;
    end
    if (s1_move) begin
      acc_r      <= acc_nxt;
      s2_state_r <= s1_state_r;
      s2_cnt_r   <= s1_cnt_r;
    end
  end

  // shift down and saturate
  assign q = acc_r >>> ROUND_SH;
  always_comb begin
    priority if (q > SAT_HI) begin
      job_value = SAT_HI[SAMPLE_W-1:0];
    end else if (q < SAT_LO) begin
      job_value = SAT_LO[SAMPLE_W-1:0];
    end else begin
      job_value = q[SAMPLE_W-1:0];
    end
  end

  assign job_valid = s2_v_r;
  assign job_cnt   = s2_cnt_r;
  assign job_state = s2_state_r;

endmodule
`default_nettype wire

@@ rtl/firsr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: job queue
// Small first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
module firsr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic          push, pop;

  assign wr_ready = count_r != (AW + 1)'(DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/firsr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: back end
// Takes one job at a time and emits its filtered word, then its state
// words oldest first, through a registered output stage.
// ----------------------------------------------------------------------------
module firsr_back #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         job_valid,
  output logic                                              job_ready,
  input  wire firsr_pkg::sample_t                           job_value,
  input  wire logic [$clog2(MAX_TAPS)-1:0]                  job_cnt,
  input  wire logic [MAX_TAPS-2:0][firsr_pkg::SAMPLE_W-1:0] job_state,
  firsr_out_if.source                                       out_ch
);
  import firsr_pkg::*;

  localparam int CW = $clog2(MAX_TAPS);
  localparam int DL = MAX_TAPS - 1;
  localparam int IW = (DL > 1) ? $clog2(DL) : 1;

  logic                        cur_v_r;
  logic                        filt_pend_r;
  logic [CW-1:0]               cnt_r;
  sample_t                     cur_value_r;
  logic [DL-1:0][SAMPLE_W-1:0] cur_state_r;

  logic                        out_v_r;
  sample_t                     out_value_r;
  kind_t                       out_kind_r;
  logic                        out_final_r;

  logic slot_free, emit, done, load;
  logic [IW-1:0] rd_idx;

  assign slot_free = !out_v_r || out_ch.ready;
  assign emit      = cur_v_r && slot_free;
  assign done      = emit && (filt_pend_r ? (cnt_r == '0) : (cnt_r == CW'(1)));
  assign job_ready = !cur_v_r || done;
  assign load      = job_valid && job_ready;
  assign rd_idx    = IW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      filt_pend_r <= 1'b0;
      cnt_r       <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (load) begin
        cur_v_r     <= 1'b1;
        filt_pend_r <= 1'b1;
        cnt_r       <= job_cnt;
      end else if (done) begin
        cur_v_r     <= 1'b0;
      end else if (emit) begin
        if (filt_pend_r) begin
          filt_pend_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (load) begin
      cur_value_r <= job_value;
      cur_state_r <= job_state;
    end
    if (emit) begin
      if (filt_pend_r) begin
        out_value_r <= cur_value_r;
        out_kind_r  <= KIND_FILTERED;
        out_final_r <= cnt_r == '0;
      end else begin
        out_value_r <= cur_state_r[rd_idx];
        out_kind_r  <= KIND_STATE;
        out_final_r <= cnt_r == CW'(1);
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.final_result = out_final_r;

  // a filtered word is final exactly when its job carries no state words
  a_filt_final: assert property (@(posedge clk) disable iff (!rst_n)
    emit && filt_pend_r |=> out_v_r && out_kind_r == KIND_FILTERED &&
                            out_final_r == ($past(cnt_r) == '0))
    else $error("filtered word final flag wrong");

  // a non-final state word waiting at the output implies more state words pending
  a_state_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_kind_r == KIND_STATE && !out_final_r |-> cur_v_r && !filt_pend_r)
    else $error("state readout ended early");

  // while reading out state words the remaining count is never zero
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r && !filt_pend_r |-> cnt_r != '0)
    else $error("state count underflow");

  // remaining count stays within the delay line depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> cnt_r <= CW'(DL))
    else $error("state count beyond delay line");

endmodule
`default_nettype wire

@@ rtl/fir_filter_with_state_readout_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter with state readout: top level
// Direct-form FIR of up to MAX_TAPS taps that reads out its newest samples
// as the final state when a block ends.
// ----------------------------------------------------------------------------
//  Channel  Dir  Words                                  Handshake
//  in_ch    in   sample (Q15), end_of_block             valid/ready
//  out_ch   out  value (Q15), kind, final_result        valid/ready
//  cfg_*    in   cfg_idx, cfg_wdata                     cfg_we, no back-pressure
//
//  One sample is taken per cycle while in_ch.ready is high; a filtered word
//  passes the product register, sum register, queue, job register and
//  output register. A sample with end_of_block gives the filtered word and
//  then one state word fewer than the effective tap count (tap_count held
//  to 1..MAX_TAPS); the four-entry queue absorbs bursts, and in_ch.ready
//  drops only once it and both front stages are full. Synchronous reset
//  clears the delay line, tap_count to one and the coefficients to zero.
// ----------------------------------------------------------------------------
module fir_filter_with_state_readout_unit #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  firsr_in_if.sink                               in_ch,
  firsr_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [firsr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [firsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import firsr_pkg::*;

  localparam int CW      = $clog2(MAX_TAPS);
  localparam int DL      = MAX_TAPS - 1;
  localparam int JOB_W   = SAMPLE_W + CW + DL * SAMPLE_W;
  localparam int Q_DEPTH = 4;

  // front to queue
  logic                        f_valid, f_ready;
  sample_t                     f_value;
  logic [CW-1:0]               f_cnt;
  logic [DL-1:0][SAMPLE_W-1:0] f_state;

  // queue to back
  logic                        b_valid, b_ready;
  logic [JOB_W-1:0]            b_data;
  sample_t                     b_value;
  logic [CW-1:0]               b_cnt;
  logic [DL-1:0][SAMPLE_W-1:0] b_state;

  // accept, multiply, sum and saturate
  firsr_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_value (f_value),
    .job_cnt   (f_cnt),
    .job_state (f_state)
  );

  // decouple the one-word-per-sample front from the multi-word readout
  firsr_queue #(.W(JOB_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_value, f_cnt, f_state}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  assign {b_value, b_cnt, b_state} = b_data;

  // emit filtered word, then state words oldest first
  firsr_back #(.MAX_TAPS(MAX_TAPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_value (b_value),
    .job_cnt   (b_cnt),
    .job_state (b_state),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ test/tb_fir_filter_with_state_readout_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: FIR filter with state readout unit
// Drives samples through the valid/ready input channel and predicts every
// filtered word and final-state word with a behavioural model of the delay
// line, the tap window and the Q15 round-and-saturate stage. Covers directed
// corner cases, a long output hold-off and randomised blocks under random
// configurations.
// ----------------------------------------------------------------------------
module tb_fir_filter_with_state_readout_unit;
  import firsr_pkg::*;

  localparam int      TAPS          = 8;
  localparam int      HALF_PERIOD   = 5;
  localparam int      RESET_CYCLES  = 12;
  localparam int      DRAIN_CYCLES  = 16;    // pipeline depth plus a full readout
  localparam int      HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int      IDLE_LIMIT    = 2000;  // cycles without any accepted word
  localparam int      RANDOM_ITEMS  = 300;
  localparam int      MAX_REPORTS   = 10;
  localparam int      FIRST_UNMAPPED_REG = int'(REG_COEF_67) + 1;
  localparam longint  ROUND_HALF    = longint'(1) << (ROUND_SH - 1);
  localparam longint  SAT_MAX       = 32767;
  localparam longint  SAT_MIN       = -32768;
  localparam sample_t SAMPLE_MAX    = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN    = 16'sh8000;
  localparam sample_t COEF_MAX      = 16'sh7FFF;  // just under +1.0
  localparam sample_t COEF_MIN      = 16'sh8000;  // exactly -1.0
  localparam sample_t COEF_HALF     = 16'sh4000;  // 0.5, gives rounding ties

  typedef struct {
    sample_t value;
    kind_t   kind;
    logic    final_result;
  } filter_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  firsr_in_if  in_ch ();
  firsr_out_if out_ch ();

  fir_filter_with_state_readout_unit #(
    .MAX_TAPS (TAPS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter model: its own copy of the tap count, coefficients and delay line
  // --------------------------------------------------------------------------
  logic [TAPS_W-1:0] tap_reg;
  sample_t           coef_q [TAPS];
  sample_t           history [TAPS-1];   // newest first
  filter_word_t      expected_words [$];

  // Run bookkeeping
  int   samples_sent;
  int   words_checked;
  int   blocks_closed;
  int   phases_run;
  int   mismatches;
  int   in_held_cycles;
  int   pressure_held;
  int   idle_run;
  logic [15:0] taps_written;

  // Idling controls shared with the receiver process
  logic in_idle_on;
  logic out_idle_on;
  int   hold_request;
  int   hold_left;
  int   stall_left;
  filter_word_t want;

  // Clamp the programmed tap count into the range the filter really uses.
  function automatic int taps_in_force();
    int t;
    t = tap_reg;
    if (t == 0) t = 1;
    if (t > TAPS) t = TAPS;
    return t;
  endfunction

  // Shift one sample in and queue every word it should produce.
  function automatic void filter_sample(input sample_t s, input logic eob);
    longint       acc;
    longint       q;
    int           t;
    int           i;
    filter_word_t w;
    t   = taps_in_force();
    acc = longint'(coef_q[0]) * longint'(s);
    for (i = 1; i < t; i++) acc += longint'(coef_q[i]) * longint'(history[i-1]);
    for (i = TAPS - 2; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    // Round half up, then saturate to Q15.
    q = (acc + ROUND_HALF) >>> ROUND_SH;
    if (q > SAT_MAX) q = SAT_MAX;
    else if (q < SAT_MIN) q = SAT_MIN;
    w.value        = q[SAMPLE_W-1:0];
    w.kind         = KIND_FILTERED;
    w.final_result = !eob || (t == 1);
    expected_words.push_back(w);
    if (eob) begin
      // Final state: the newest t-1 samples, oldest first.
      for (i = t - 2; i >= 0; i--) begin
        w.value        = history[i];
        w.kind         = KIND_STATE;
        w.final_result = (i == 0);
        expected_words.push_back(w);
      end
      foreach (history[k]) history[k] = '0;
      blocks_closed++;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TAP_COUNT: begin
        tap_reg = data[TAPS_W-1:0];
        taps_written[data[TAPS_W-1:0]] = 1'b1;
      end
      REG_COEF_01: begin
        coef_q[0] = data[COEF_W-1:0];
        coef_q[1] = data[2*COEF_W-1:COEF_W];
      end
      REG_COEF_23: begin
        coef_q[2] = data[COEF_W-1:0];
        coef_q[3] = data[2*COEF_W-1:COEF_W];
      end
      REG_COEF_45: begin
        coef_q[4] = data[COEF_W-1:0];
        coef_q[5] = data[2*COEF_W-1:COEF_W];
      end
      REG_COEF_67: begin
        coef_q[6] = data[COEF_W-1:0];
        coef_q[7] = data[2*COEF_W-1:COEF_W];
      end
      default: ;  // unmapped index: the block drops the write
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sample_t rand_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef_pair();
    return {rand_coef(), rand_coef()};
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks: configuration writes, sample sender, drain
  // --------------------------------------------------------------------------
  // Leave cfg_we high so back-to-back writes never lower and raise it in one
  // step; the caller drops it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic configure(input logic [TAPS_W-1:0] taps,
                           input logic [CFG_DATA_W-1:0] c01,
                           input logic [CFG_DATA_W-1:0] c23,
                           input logic [CFG_DATA_W-1:0] c45,
                           input logic [CFG_DATA_W-1:0] c67);
    cfg_write(REG_TAP_COUNT, CFG_DATA_W'(taps));
    cfg_write(REG_COEF_01, c01);
    cfg_write(REG_COEF_23, c23);
    cfg_write(REG_COEF_45, c45);
    cfg_write(REG_COEF_67, c67);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample and hold it until the block takes it. Valid stays high
  // into the next call when that call has no gap.
  task automatic send_sample(input sample_t s, input logic eob);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.end_of_block <= eob;
    do @(posedge clk); while (!in_ch.ready);
    filter_sample(s, eob);
    samples_sent++;
  endtask

  // Stop offering, wait for every predicted word, then let the pipe settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------
  // Reset values: one tap, zero coefficients, so every filtered word is zero
  // and a block end gives no state words.
  task automatic check_reset_state();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  // Tap count of zero and above the maximum, rounding ties and saturation
  // in both directions.
  task automatic check_tap_limits();
    int i;
    wait_drained();
    // Zero taps acts as one; the higher coefficients must not leak in.
    configure('0, {COEF_MAX, COEF_HALF}, {COEF_MAX, COEF_MAX},
              {COEF_MAX, COEF_MAX}, {COEF_MAX, COEF_MAX});
    send_sample(16'sd1, 1'b0);    // +0.5 LSB tie rounds up
    send_sample(-16'sd1, 1'b0);   // -0.5 LSB tie rounds up to zero
    send_sample(SAMPLE_MAX, 1'b1);
    wait_drained();
    // Fifteen taps clamp to the maximum; -1.0 times -1.0 overflows upwards.
    configure('1, {COEF_MIN, COEF_MIN}, {COEF_MIN, COEF_MIN},
              {COEF_MIN, COEF_MIN}, {COEF_MIN, COEF_MIN});
    for (i = 0; i < TAPS; i++) send_sample(SAMPLE_MIN, i == TAPS - 1);
    wait_drained();
    // Block end before the delay line has filled; negative overflow.
    configure(TAPS_W'(TAPS), {COEF_MAX, COEF_MAX}, {COEF_MAX, COEF_MAX},
              {COEF_MAX, COEF_MAX}, {COEF_MAX, COEF_MAX});
    for (i = 0; i < 4; i++) send_sample(SAMPLE_MIN, i == 3);
  endtask

  // Writes to indexes past the last register must leave the setup alone.
  task automatic check_unmapped_regs();
    int i;
    wait_drained();
    for (i = FIRST_UNMAPPED_REG; i < 2 ** CFG_IDX_W; i++)
      cfg_write(i[CFG_IDX_W-1:0], $urandom());
    cfg_we <= 1'b0;
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b1);
  endtask

  // Hold the output off for a long stretch while samples keep coming, so the
  // queue fills and the input must stall.
  task automatic check_backpressure();
    int i;
    int held_before;
    wait_drained();
    configure(TAPS_W'(TAPS), rand_coef_pair(), rand_coef_pair(),
              rand_coef_pair(), rand_coef_pair());
    in_idle_on   = 1'b0;
    out_idle_on  = 1'b0;
    held_before  = in_held_cycles;
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 32; i++) send_sample(rand_sample(), (i % 5) == 4);
    pressure_held = in_held_cycles - held_before;
  endtask

  // Phases of random blocks, each phase under a fresh configuration and its
  // own idling mode. A few blocks run on without an end marker.
  task automatic check_random_blocks();
    int                sent;
    int                phase_len;
    int                done;
    int                blk;
    int                k;
    logic              open_end;
    logic [TAPS_W-1:0] taps;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       taps = '0;
        1:       taps = TAPS_W'(1);
        2:       taps = TAPS_W'(TAPS);
        3:       taps = '1;
        default: taps = TAPS_W'($urandom_range(0, 15));
      endcase
      configure(taps, rand_coef_pair(), rand_coef_pair(),
                rand_coef_pair(), rand_coef_pair());
      {in_idle_on, out_idle_on} = 2'($urandom_range(0, 3));
      phases_run++;
      phase_len = $urandom_range(20, 50);
      done      = 0;
      while (done < phase_len) begin
        blk      = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9)
                                              : $urandom_range(10, 30);
        open_end = ($urandom_range(0, 9) == 0);
        for (k = 0; k < blk; k++)
          send_sample(rand_sample(), (k == blk - 1) && !open_end);
        done += blk;
      end
      sent += done;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = (($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                               : $urandom_range(8, 40)) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare every accepted word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word value %0d kind %0b final %0b",
                                out_ch.value, out_ch.kind, out_ch.final_result));
      end else begin
        want = expected_words.pop_front();
        if (out_ch.value !== want.value || out_ch.kind !== want.kind ||
            out_ch.final_result !== want.final_result)
          note_mismatch($sformatf(
            "word %0d: expected value %0d kind %0b final %0b, got %0d %0b %0b",
            words_checked, want.value, want.kind, want.final_result,
            out_ch.value, out_ch.kind, out_ch.final_result));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no word accepted on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) in_held_cycles++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_run = 0;
    else
      idle_run++;
    if (idle_run >= IDLE_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.end_of_block = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    tap_reg            = TAPS_W'(1);
    foreach (coef_q[k]) coef_q[k] = '0;
    foreach (history[k]) history[k] = '0;
    samples_sent   = 0;
    words_checked  = 0;
    blocks_closed  = 0;
    phases_run     = 0;
    mismatches     = 0;
    in_held_cycles = 0;
    pressure_held  = 0;
    idle_run       = 0;
    taps_written   = '0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    hold_request   = 0;
    hold_left      = 0;
    stall_left     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reset_state();
    check_tap_limits();
    check_unmapped_regs();
    check_backpressure();
    check_random_blocks();
    wait_drained();

    $display("Run covered %0d samples over %0d random phases, %0d blocks closed, %0d words checked.",
             samples_sent, phases_run, blocks_closed, words_checked);
    $display("Tap settings written: %0d distinct; input stalled %0d cycles under the long hold-off.",
             $countones(taps_written), pressure_held);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/firsr_pkg.sv
rtl/firsr_if.sv
rtl/firsr_front.sv
rtl/firsr_queue.sv
rtl/firsr_back.sv
rtl/fir_filter_with_state_readout_unit.sv
test/tb_fir_filter_with_state_readout_unit.sv
